// ----- design/prrs_pkg.sv -----
// Shared types and constants for the preemptive response-ratio scheduler.
// No dependencies; prrs_if, prrs_div and the top level import this package.
package prrs_pkg;

    localparam int REM_W  = 16;
    localparam int WAIT_W = 32;
    localparam int PC_W   = 5;
    localparam int SLOT_W = 4;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // item kind codes
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // one slot entry as stored in the slot table
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [WAIT_W-1:0] wt;
    } entry_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [WAIT_W-1:0] dividend;
        logic [REM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WAIT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- design/prrs_if.sv -----
// Valid/ready channel interfaces for scheduler items and results.
// Depends on prrs_pkg for field widths.
interface prrs_in_if;
    import prrs_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [REM_W-1:0]  burst;

    modport source (output valid, kind, slot, burst, input ready);
    modport sink   (input valid, kind, slot, burst, output ready);
endinterface

interface prrs_out_if;
    import prrs_pkg::*;

    logic              valid;
    logic              ready;
    logic              ran_valid;
    logic [SLOT_W-1:0] ran_slot;
    logic [WAIT_W-1:0] elapsed;
    logic              all_done;

    modport source (output valid, ran_valid, ran_slot, elapsed, all_done, input ready);
    modport sink   (input valid, ran_valid, ran_slot, elapsed, all_done, output ready);
endinterface

// ----- design/prrs_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module prrs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- design/prrs_div.sv -----
// Radix-2 restoring divider: 32-bit wait by 16-bit remaining time.
// Depends on prrs_pkg (div_req_t, div_rsp_t). One quotient bit per cycle.
module prrs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  prrs_pkg::div_req_t req,
    output prrs_pkg::div_rsp_t rsp
);
    import prrs_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [REM_W-1:0]  acc_reg;
    logic [WAIT_W-1:0] quo_reg;
    logic [REM_W-1:0]  dsr_reg;

    logic [REM_W:0]    trial;
    logic              ge;
    logic [REM_W:0]    diff;

    always_comb
    begin
        trial = {acc_reg, quo_reg[WAIT_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                acc_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                quo_reg <= {quo_reg[WAIT_W-2:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

// ----- design/preemptive_response_ratio_scheduler_top.sv -----
// Top level of the preemptive response-ratio scheduler.
// Depends on prrs_pkg, prrs_if (channels), prrs_ram and prrs_div.
//
// Channel   Dir  Handshake          Beat contents
// in_ch     in   valid/ready        kind, slot, burst
// out_ch    out  valid/ready        ran_valid, ran_slot, elapsed, all_done
// cfg       in   cfg_wr_en, no wait proc_count (cfg_wr_data)
//
// Passes: a tick makes a priority pass (reads each active slot and runs the
// bit-serial divider for each slot with time left) and, if any slot has time
// left, an update pass over the active slots.
// A load item is one write plus a scan of the active slots for all_done.
// Reset: per-entry valid bits clear at once; no clearing pass is run.
// Stalls: one item in flight; the result register holds a beat for out_ch,
// the next item is taken while it waits, and completion waits for it to drain.
module preemptive_response_ratio_scheduler_top #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [prrs_pkg::PC_W-1:0] cfg_wr_data,
    prrs_in_if.sink                 in_ch,
    prrs_out_if.source              out_ch
);
    import prrs_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);        // slot address bits
    localparam int CW = $clog2(MAX_SLOTS + 1);    // count bits, holds MAX_SLOTS
    localparam int PW = (IW > SLOT_W) ? IW : SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,      // priority pass: read slot
        S_CHK1,     // priority pass: entry data, start divider
        S_DIV,      // priority pass: wait for quotient, compare
        S_RD2,      // update/scan pass: read slot
        S_UPD2,     // update/scan pass: modify, write back
        S_FIN       // hand the result to the output register
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     idx_reg;
    logic              found_reg;
    logic [IW-1:0]     win_reg;
    logic [WAIT_W-1:0] best_reg;
    logic              mod_reg;     // update pass writes back
    logic              left_reg;    // some active slot has time left
    logic              res_ran_reg;
    logic [WAIT_W-1:0] tick_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic              vld_q_reg;

    logic              out_valid_reg;
    logic              out_ran_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [WAIT_W-1:0] out_elapsed_reg;
    logic              out_done_reg;

    logic [CW-1:0]     act;
    logic [CW-1:0]     act_m1;
    logic              last;
    logic [IW-1:0]     addr;
    logic              in_fire;
    logic              load_wr;
    logic              out_load;
    logic              in_range;

    entry_t            rd_entry;
    entry_t            cur;
    entry_t            upd;
    logic [PW-1:0]     win_ext;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // active slot count: 0 acts as 1, clamp at the table size
    always_comb
    begin
        if (pc_reg == '0)
        begin
            act = CW'(1);
        end
        else if (32'(pc_reg) > 32'(MAX_SLOTS))
        begin
            act = CW'(MAX_SLOTS);
        end
        else
        begin
            act = CW'(pc_reg);
        end
    end

    assign act_m1   = act - CW'(1);
    assign last     = (idx_reg == act_m1);
    assign addr     = idx_reg[IW-1:0];
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign in_range = 32'(in_ch.slot) < 32'(MAX_SLOTS);
    assign load_wr  = in_fire && (in_ch.kind == KIND_LOAD) && in_range;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    // never-loaded entries read as zero
    assign cur = vld_q_reg ? rd_entry : '0;

    // update pass: winner runs a tick, other unfinished slots wait one more
    always_comb
    begin
        upd = cur;
        if (mod_reg)
        begin
            if (addr == win_reg)
            begin
                upd.rem = cur.rem - REM_W'(1);
            end
            else if (cur.rem != '0 && cur.wt != WAIT_MAX)
            begin
                upd.wt = cur.wt + WAIT_W'(1);
            end
        end
    end

    // single write port: load at accept, write-back in the update pass
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            ram_we        = load_wr;
            ram_waddr     = IW'(in_ch.slot);
            ram_wdata.rem = in_ch.burst;
            ram_wdata.wt  = '0;
        end
        else
        begin
            ram_we    = (state_reg == S_UPD2) && mod_reg;
            ram_waddr = addr;
            ram_wdata = upd;
        end
    end

    assign ram_re = (state_reg == S_RD1) || (state_reg == S_RD2);

    assign div_req.start    = (state_reg == S_CHK1) && (cur.rem != '0);
    assign div_req.dividend = cur.wt;
    assign div_req.divisor  = cur.rem;

    prrs_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (rd_entry)
    );

    prrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration register and entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_W'(1);
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pc_reg <= cfg_wr_data;
            end
            if (load_wr)
            begin
                valid_reg[IW'(in_ch.slot)] <= 1'b1;
            end
            if (ram_re)
            begin
                vld_q_reg <= valid_reg[addr];
            end
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            win_reg         <= '0;
            best_reg        <= '0;
            mod_reg         <= 1'b0;
            left_reg        <= 1'b0;
            res_ran_reg     <= 1'b0;
            tick_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_ran_reg     <= 1'b0;
            out_slot_reg    <= '0;
            out_elapsed_reg <= '0;
            out_done_reg    <= 1'b0;
        end
        else
        begin
            // beat taken and no new one loaded behind it
            if (out_ch.valid && out_ch.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        left_reg    <= 1'b0;
                        res_ran_reg <= 1'b0;
                        mod_reg     <= 1'b0;
                        if (in_ch.kind == KIND_TICK)
                        begin
                            state_reg <= S_RD1;
                        end
                        else
                        begin
                            state_reg <= S_RD2;
                        end
                    end
                end

                S_RD1:
                begin
                    state_reg <= S_CHK1;
                end

                S_CHK1, S_DIV:
                begin
                    if (state_reg == S_CHK1 && cur.rem != '0)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (state_reg == S_DIV && div_rsp.done
                            && (!found_reg || div_rsp.quot > best_reg))
                        begin
                            best_reg  <= div_rsp.quot;
                            win_reg   <= addr;
                            found_reg <= 1'b1;
                        end
                        if (state_reg == S_CHK1 || div_rsp.done)
                        begin
                            if (!last)
                            begin
                                idx_reg   <= idx_reg + CW'(1);
                                state_reg <= S_RD1;
                            end
                            else
                            begin
                                // end of priority pass
                                idx_reg <= '0;
                                if (found_reg || (state_reg == S_DIV))
                                begin
                                    mod_reg     <= 1'b1;
                                    res_ran_reg <= 1'b1;
                                    if (tick_reg != WAIT_MAX)
                                    begin
                                        tick_reg <= tick_reg + WAIT_W'(1);
                                    end
                                    state_reg <= S_RD2;
                                end
                                else
                                begin
                                    // nothing to run
                                    left_reg  <= 1'b0;
                                    state_reg <= S_FIN;
                                end
                            end
                        end
                    end
                end

                S_RD2:
                begin
                    state_reg <= S_UPD2;
                end

                S_UPD2:
                begin
                    if (upd.rem != '0)
                    begin
                        left_reg <= 1'b1;
                    end
                    if (last)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_RD2;
                    end
                end

                S_FIN:
                begin
                    if (out_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_ran_reg     <= res_ran_reg;
                        out_slot_reg    <= res_ran_reg ? win_ext[SLOT_W-1:0] : '0;
                        out_elapsed_reg <= tick_reg;
                        out_done_reg    <= !left_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign win_ext = PW'(win_reg);

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.ran_valid = out_ran_reg;
    assign out_ch.ran_slot  = out_slot_reg;
    assign out_ch.elapsed   = out_elapsed_reg;
    assign out_ch.all_done  = out_done_reg;

    // quotient only arrives while the priority pass waits on it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider result outside the wait state");

    // table writes only at a load accept or in the update pass
    a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_IDLE && in_fire) || (state_reg == S_UPD2 && mod_reg)))
        else $error("table write outside load or update");

    // the slot being run lies inside the active range
    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD2 && mod_reg) |-> (CW'(win_reg) < act))
        else $error("winner outside active slots");

    // a tick that ran has advanced the tick count
    a_ran_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_ran_reg) |=> (out_ch.elapsed != '0))
        else $error("ran result with zero elapsed time");

    // a result is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready && state_reg == S_FIN) |=> (state_reg == S_FIN))
        else $error("result register overrun");
endmodule

// ----- tb/tb_preemptive_response_ratio_scheduler_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for preemptive_response_ratio_scheduler_top.
// Walks a directed stimulus table, then random load/tick sequences, and checks each beat
// against a typed result or the in-bench model. Needs prrs_pkg, prrs_if and the scheduler RTL.
module tb_preemptive_response_ratio_scheduler_top;
    import prrs_pkg::*;

    localparam int NSLOTS       = 16;
    // Worst tick: full priority pass with every slot dividing, plus the update pass.
    localparam int TICK_LATENCY = 4 * NSLOTS + 33 * NSLOTS + 2;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_SETTLE  = 20;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;
    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    // One result beat as seen on out_ch.
    typedef struct packed {
        logic              ran_valid;
        logic [SLOT_W-1:0] ran_slot;
        logic [WAIT_W-1:0] elapsed;
        logic              all_done;
    } grant_t;

    // Directed stimulus row. For ROW_CFG the proc_count value rides in burst.
    typedef struct {
        row_op_t           op;
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [REM_W-1:0]  burst;
        bit                typed;
        grant_t            want;
    } stim_row_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [PC_W-1:0] cfg_wr_data;

    prrs_in_if  in_ch();
    prrs_out_if out_ch();

    preemptive_response_ratio_scheduler_top #(
        .MAX_SLOTS (NSLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // ------------------------------------------------------------------
    // Scheduler model state: mirrors the slot table, the tick counter and
    // the proc_count register as the DUT should hold them.
    // ------------------------------------------------------------------
    logic [REM_W-1:0]  rem_left [NSLOTS];
    logic [WAIT_W-1:0] waited   [NSLOTS];
    logic [WAIT_W-1:0] ticks_run;
    logic [PC_W-1:0]   proc_count_q;
    logic              last_all_done;

    grant_t      grant_q [$];   // expected beats, oldest first
    stim_row_t   rows    [$];

    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned runs_seen;
    int unsigned loads_sent;
    int unsigned ticks_sent;
    int unsigned cfg_writes;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: reports FAILED and stops the simulation if the run has not ended.
    initial
    begin
        #60_000_000;
        $display("** preemptive_response_ratio_scheduler_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // proc_count of 0 behaves as 1, anything above the table size as the table size.
    function automatic int unsigned active_count();
        if (proc_count_q == '0)
            return 1;
        if (proc_count_q > NSLOTS)
            return NSLOTS;
        return 32'(proc_count_q);
    endfunction

    // Apply one accepted item to the model and return the beat it must produce.
    function automatic grant_t schedule_item(input logic kind, input logic [SLOT_W-1:0] slot,
                                             input logic [REM_W-1:0] burst);
        grant_t          g;
        int unsigned     n;
        int unsigned     win;
        bit              ran;
        logic [WAIT_W:0] prio;
        logic [WAIT_W:0] best;

        n    = active_count();
        win  = 0;
        ran  = 1'b0;
        best = '0;

        if (kind == KIND_LOAD)
        begin
            rem_left[slot] = burst;
            waited[slot]   = '0;
        end
        else
        begin
            // response ratio 1 + wait/remaining; strict compare keeps the lowest index on ties
            for (int i = 0; i < n; i++)
            begin
                if (rem_left[i] != '0)
                begin
                    prio = 1 + waited[i] / rem_left[i];
                    if (!ran || prio > best)
                    begin
                        best = prio;
                        win  = i;
                        ran  = 1'b1;
                    end
                end
            end
            if (ran)
            begin
                for (int i = 0; i < n; i++)
                    if (i != win && rem_left[i] != '0 && waited[i] != WAIT_MAX)
                        waited[i] = waited[i] + WAIT_W'(1);
                rem_left[win] = rem_left[win] - REM_W'(1);
                if (ticks_run != WAIT_MAX)
                    ticks_run = ticks_run + WAIT_W'(1);
            end
        end

        g.ran_valid = ran;
        g.ran_slot  = ran ? SLOT_W'(win) : '0;
        g.elapsed   = ticks_run;
        g.all_done  = 1'b1;
        for (int i = 0; i < n; i++)
            if (rem_left[i] != '0)
                g.all_done = 1'b0;
        return g;
    endfunction

    function automatic grant_t mk_grant(input logic v, input logic [SLOT_W-1:0] s,
                                        input logic [WAIT_W-1:0] e, input logic d);
        grant_t g;
        g.ran_valid = v;
        g.ran_slot  = s;
        g.elapsed   = e;
        g.all_done  = d;
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one beat per call, idle gaps drawn before it
    // ------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [REM_W-1:0] burst, input bit typed, input grant_t want);
        grant_t g;

        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.slot  <= slot;
        in_ch.burst <= burst;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);

        // beat taken: advance the model in acceptance order
        g = schedule_item(kind, slot, burst);
        grant_q.push_back(typed ? want : g);
        last_all_done = g.all_done;
        if (kind == KIND_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    // Drop valid and wait until every expected beat has drained.
    task automatic settle_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    // proc_count is only changed with nothing in flight.
    task automatic write_proc_count(input logic [PC_W-1:0] value);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        proc_count_q = value;
        cfg_writes++;
    endtask

    task automatic add_row(input row_op_t op, input logic kind, input logic [SLOT_W-1:0] slot,
                           input logic [REM_W-1:0] burst, input bit typed, input grant_t want);
        stim_row_t r;
        r.op    = op;
        r.kind  = kind;
        r.slot  = slot;
        r.burst = burst;
        r.typed = typed;
        r.want  = want;
        rows.push_back(r);
    endtask

    // One well-formed job set: pick a slot count, load every active slot,
    // then tick until everything has run (or a cap, if noise keeps it busy).
    task automatic run_sequence();
        int unsigned       r;
        int unsigned       n;
        int unsigned       ticks_left;
        logic [PC_W-1:0]   pc;
        logic [SLOT_W-1:0] s;
        logic [REM_W-1:0]  b;
        grant_t            none_g;

        none_g = '0;
        r = $urandom_range(99);
        if (r < 8)
            pc = PC_W'(NSLOTS);
        else if (r < 12)
            pc = '1;                                // above the table: clamps
        else if (r < 15)
            pc = '0;                                // zero: acts as one slot
        else if (r < 20)
            pc = PC_W'($urandom_range(30, 17));
        else
            pc = PC_W'($urandom_range(8, 1));
        write_proc_count(pc);
        n = active_count();

        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                b = '0;
            else if (r < 8)
                b = REM_W'($urandom_range(40, 7));
            else
                b = REM_W'($urandom_range(6, 1));
            send_item(KIND_LOAD, SLOT_W'(i), b, 1'b0, none_g);
        end

        ticks_left = 8 * n + 10;
        while (ticks_left != 0)
        begin
            // noise: stray reloads; full-range bursts only on parked slots
            if ($urandom_range(99) < 8)
            begin
                s = SLOT_W'($urandom_range(NSLOTS - 1));
                if (s < n)
                    b = REM_W'($urandom_range(6, 0));
                else
                    b = REM_W'($urandom_range(65535, 0));
                send_item(KIND_LOAD, s, b, 1'b0, none_g);
            end
            send_item(KIND_TICK, '0, '0, 1'b0, none_g);
            ticks_left--;
            if (last_all_done)
            begin
                // sometimes a tick with nothing left to run
                if ($urandom_range(1) != 0)
                    send_item(KIND_TICK, SLOT_W'($urandom_range(NSLOTS - 1)),
                              REM_W'($urandom_range(65535, 0)), 1'b0, none_g);
                ticks_left = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure and the beat checker
    // ------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic note_mismatch(input grant_t want, input grant_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: beat mismatch: exp ran_valid=%0b ran_slot=%0d elapsed=%0d all_done=%0b",
                     $realtime, want.ran_valid, want.ran_slot, want.elapsed, want.all_done,
                     " | got ran_valid=%0b ran_slot=%0d elapsed=%0d all_done=%0b",
                     got.ran_valid, got.ran_slot, got.elapsed, got.all_done);
    endtask

    always @(posedge clk)
    begin : check_beats
        grant_t got;
        grant_t want;

        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.ran_valid = out_ch.ran_valid;
            got.ran_slot  = out_ch.ran_slot;
            got.elapsed   = out_ch.elapsed;
            got.all_done  = out_ch.all_done;
            beats_checked++;
            if (got.ran_valid === 1'b1)
                runs_seen++;
            if (grant_q.size() == 0)
            begin
                // a beat nobody asked for
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat ran_valid=%0b ran_slot=%0d elapsed=%0d",
                             $realtime, got.ran_valid, got.ran_slot, got.elapsed);
            end
            else
            begin
                want = grant_q.pop_front();
                if (got.ran_valid !== want.ran_valid || got.ran_slot !== want.ran_slot ||
                    got.elapsed !== want.elapsed || got.all_done !== want.all_done)
                    note_mismatch(want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_flow
        int unsigned directed_items;
        int unsigned phase;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_LOAD;
        in_ch.slot    = '0;
        in_ch.burst   = '0;
        mismatches    = 0;
        beats_checked = 0;
        runs_seen     = 0;
        loads_sent    = 0;
        ticks_sent    = 0;
        cfg_writes    = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        last_all_done = 1'b1;
        proc_count_q  = PC_W'(1);
        ticks_run     = '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            rem_left[i] = '0;
            waited[i]   = '0;
        end

        // Directed table. Rows with typed results hold at reset-time state
        // with one slot active; the rest go through the model.
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     1, mk_grant(0, 0, 0, 1)); // idle tick
        add_row(ROW_ITEM, KIND_LOAD, 4'd0,  16'd0,     1, mk_grant(0, 0, 0, 1)); // zero burst
        add_row(ROW_ITEM, KIND_LOAD, 4'd15, 16'hFFFF,  1, mk_grant(0, 0, 0, 1)); // parked slot
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     1, mk_grant(0, 0, 0, 1));
        add_row(ROW_ITEM, KIND_LOAD, 4'd0,  16'd2,     1, mk_grant(0, 0, 0, 0));
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     1, mk_grant(1, 0, 1, 0));
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     1, mk_grant(1, 0, 2, 1)); // last one runs
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     1, mk_grant(0, 0, 2, 1));
        // full table: slot 15 joins with the largest burst
        add_row(ROW_CFG,  KIND_LOAD, 4'd0,  16'd16,    0, '0);
        add_row(ROW_ITEM, KIND_LOAD, 4'd1,  16'd3,     0, '0);
        add_row(ROW_ITEM, KIND_LOAD, 4'd2,  16'd1,     0, '0);
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0); // tie at ratio 1: lowest wins
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0); // waited slot overtakes
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0);
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0);
        add_row(ROW_ITEM, KIND_LOAD, 4'd15, 16'd0,     0, '0);
        add_row(ROW_ITEM, KIND_LOAD, 4'd3,  16'hFFFF,  0, '0);
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0);
        // zero count acts as one slot, slot 0 is empty
        add_row(ROW_CFG,  KIND_LOAD, 4'd0,  16'd0,     0, '0);
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0);
        // all-ones count clamps to the table size
        add_row(ROW_CFG,  KIND_LOAD, 4'd0,  16'd31,    0, '0);
        add_row(ROW_ITEM, KIND_LOAD, 4'd10, 16'hA5A5,  0, '0);
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0);
        add_row(ROW_ITEM, KIND_TICK, 4'd0,  16'd0,     0, '0);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].op == ROW_CFG)
                write_proc_count(rows[i].burst[PC_W-1:0]);
            else
                send_item(rows[i].kind, rows[i].slot, rows[i].burst, rows[i].typed, rows[i].want);
        end
        directed_items = loads_sent + ticks_sent;

        // Random part in four backpressure phases.
        while (loads_sent + ticks_sent < directed_items + RANDOM_ITEMS)
        begin
            phase = (loads_sent + ticks_sent - directed_items) / PHASE_ITEMS;
            case (phase)
                IDLE_NONE:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                IDLE_SRC:
                begin
                    src_idle_pct  = 85;
                    snk_stall_pct = 0;
                end
                IDLE_SNK:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 85;
                end
                default:
                begin
                    src_idle_pct  = 37;
                    snk_stall_pct = 37;
                end
            endcase
            run_sequence();
        end

        // Drain, then give the block a full tick's time to show any stray beat.
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(negedge clk);
        repeat (TICK_LATENCY) @(negedge clk);

        $display("Run covered %0d loads, %0d ticks (%0d slot runs) over %0d proc_count settings,",
                 loads_sent, ticks_sent, runs_seen, cfg_writes);
        $display("%0d beats checked, %0d mismatches, %0d beats still owed.",
                 beats_checked, mismatches, grant_q.size());
        if (mismatches == 0 && grant_q.size() == 0)
            $display("** preemptive_response_ratio_scheduler_top: PASSED **");
        else
            $display("** preemptive_response_ratio_scheduler_top: FAILED **");
        $finish;
    end

endmodule
